// ===== hdl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// Deque package
// Shared beat types, operation and status codes, and the command and status
// groups that pass between the deque controller and its datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

   // Fixed field widths of the request and response beats.
   localparam int unsigned POS_W = 6;
   localparam int unsigned VAL_W = 32;
   localparam int unsigned CNT_W = 7;

   // Operation selector carried by each request beat.
   typedef enum logic [2:0] {
      MODE_PUSH_HEAD = 3'd0,
      MODE_PUSH_TAIL = 3'd1,
      MODE_POP_HEAD  = 3'd2,
      MODE_POP_TAIL  = 3'd3,
      MODE_CLEAR     = 3'd4,
      MODE_READ      = 3'd5,
      MODE_WRITE     = 3'd6,
      MODE_DELETE    = 3'd7
   } mode_type;

   // Status code returned with each response beat.
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_ABSENT  = 2'd1,
      ST_FULL    = 2'd2,
      ST_BAD_POS = 2'd3
   } status_type;

   // Request beat.
   typedef struct packed {
      mode_type                  mode;
      logic signed [VAL_W-1:0]   value;
      logic        [POS_W-1:0]   position;
   } req_type;

   // Response beat.
   typedef struct packed {
      logic signed [VAL_W-1:0]   read_value;
      status_type                status;
      logic        [CNT_W-1:0]   count;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       latch_req;
      logic       push_head;
      logic       push_tail;
      logic       pop_head;
      logic       pop_tail;
      logic       clear_all;
      logic       write_at;
      logic       read_at;
      logic       shift_start;
      logic       shift_step;
      logic       set_result;
      status_type result_status;
      logic       capture_read;
      logic       load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      mode_type mode;
      logic     full;
      logic     empty;
      logic     pos_ok;
      logic     pos_zero;
      logic     more_after_pos;
      logic     shift_more;
   } sts_type;

endpackage

// ===== hdl/deque_indexed_access_delete.sv =====
// ----------------------------------------------------------------------------
// Deque with indexed access and delete
// Bounded double-ended queue of signed values with push and pop at both
// ends, clear, and read, write and delete at a position counted from the head.
// ----------------------------------------------------------------------------
// Each request beat gives exactly one response beat carrying the value read
// (all ones unless a read succeeds), a status code and the entry count after
// the operation. Requests are handled one at a time: a request is taken only
// while the controller is idle, and a finished response waits in its own
// register so the next request can be taken meanwhile. A read passes
// through an extra wait state because of the registered memory read.
// Delete at position p with n entries held moves n - p - 1 entries
// through the single memory write port, one per cycle. Entries are never
// read before they are written, so the memory needs no clearing after
// reset.
module deque_indexed_access_delete #(
   parameter int unsigned DEPTH      = 64,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  deq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output deq_pkg::rsp_type rsp_data
);
   import deq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Operation sequencing.
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Storage, pointers and result registers.
   deq_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

// ===== hdl/deq_dp.sv =====
// ----------------------------------------------------------------------------
// Deque datapath
// Circular entry memory, head and count registers, the shift index used by
// delete, and the result and response registers.
// ----------------------------------------------------------------------------
module deq_dp #(
   parameter int unsigned DEPTH      = 64,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  deq_pkg::req_type req_data,
   input  deq_pkg::cmd_type cmd,
   output deq_pkg::sts_type sts,
   output deq_pkg::rsp_type rsp_data
);
   import deq_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;
   localparam int unsigned OW = CW + 1;

   // Physical slot of an entry given its offset from the head.
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                             input logic [OW-1:0] offset);
      logic [OW:0] sum;
      sum = (OW+1)'(head) + (OW+1)'(offset);
      if (sum >= (OW+1)'(DEPTH)) begin
         sum = sum - (OW+1)'(DEPTH);
      end
      return AW'(sum);
   endfunction

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;

   mode_type              mode_ff;
   logic [DATA_WIDTH-1:0] value_ff;
   logic [POS_W-1:0]      pos_ff;

   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         idx_ff, idx_in;

   logic [DATA_WIDTH-1:0] res_value_ff;
   status_type            res_status_ff;
   rsp_type               rsp_data_ff;

   logic [OW-1:0]         pos_off;
   logic [OW-1:0]         idx_off;
   logic [OW-1:0]         count_off;
   logic [AW-1:0]         head_inc;
   logic [AW-1:0]         head_dec;

   logic                  we;
   logic [AW-1:0]         waddr;
   logic [DATA_WIDTH-1:0] wdata;
   logic [AW-1:0]         raddr;

   // Offsets from the head, widened so that the sums below cannot wrap.
   assign pos_off   = OW'(pos_ff);
   assign idx_off   = OW'(idx_ff);
   assign count_off = OW'(count_ff);

   assign head_inc = slot_of(head_ff, OW'(1));
   assign head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);

   // Status toward the controller.
   assign sts.mode           = mode_ff;
   assign sts.full           = (count_ff == CW'(DEPTH));
   assign sts.empty          = (count_ff == '0);
   assign sts.pos_ok         = (PW'(pos_ff) < PW'(count_ff));
   assign sts.pos_zero       = (pos_ff == '0);
   assign sts.more_after_pos = ((pos_off + OW'(1)) < count_off);
   assign sts.shift_more     = ((idx_off + OW'(2)) < count_off);

   // Head and count updates.
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.clear_all) begin
         head_in  = '0;
         count_in = '0;
      end else if (cmd.push_head) begin
         head_in  = head_dec;
         count_in = count_ff + CW'(1);
      end else if (cmd.push_tail) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop_head) begin
         head_in  = head_inc;
         count_in = count_ff - CW'(1);
      end else if (cmd.pop_tail) begin
         count_in = count_ff - CW'(1);
      end
   end

   // Shift index walks from the deleted position toward the tail.
   always_comb begin
      idx_in = idx_ff;
      if (cmd.shift_start) begin
         idx_in = CW'(pos_ff);
      end else if (cmd.shift_step) begin
         idx_in = idx_ff + CW'(1);
      end
   end

   // Memory write port selection.
   always_comb begin
      we    = 1'b0;
      waddr = slot_of(head_ff, idx_off);
      wdata = value_ff;
      if (cmd.push_head) begin
         we    = 1'b1;
         waddr = head_dec;
      end else if (cmd.push_tail) begin
         we    = 1'b1;
         waddr = slot_of(head_ff, count_off);
      end else if (cmd.write_at) begin
         we    = 1'b1;
         waddr = slot_of(head_ff, pos_off);
      end else if (cmd.shift_step) begin
         we    = 1'b1;
         wdata = rdata_ff;
      end
   end

   // Memory read address: the requested entry, or the entry that moves next.
   always_comb begin
      if (cmd.read_at) begin
         raddr = slot_of(head_ff, pos_off);
      end else if (cmd.shift_start) begin
         raddr = slot_of(head_ff, pos_off + OW'(1));
      end else begin
         raddr = slot_of(head_ff, idx_off + OW'(2));
      end
   end

   // Entry memory with registered read data.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Payload registers: request fields, shift index, result and response.
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.latch_req) begin
         mode_ff  <= req_data.mode;
         value_ff <= DATA_WIDTH'(req_data.value);
         pos_ff   <= req_data.position;
      end
      if (cmd.set_result) begin
         res_value_ff  <= '1;
         res_status_ff <= cmd.result_status;
      end else if (cmd.capture_read) begin
         res_value_ff <= rdata_ff;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff.read_value <= VAL_W'(res_value_ff);
         rsp_data_ff.status     <= res_status_ff;
         rsp_data_ff.count      <= CNT_W'(count_ff);
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

// ===== hdl/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Deque controller
// Sequences one request at a time: accept, execute, optional memory read or
// delete shift, then hand the result to the response register.
// ----------------------------------------------------------------------------
module deq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  deq_pkg::sts_type sts,
   output deq_pkg::cmd_type cmd
);
   import deq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_RDWAIT,
      S_SHIFT,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath commands.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.set_result    = 1'b1;
            cmd.result_status = ST_OK;
            state_in          = S_EMIT;
            unique case (sts.mode)
               MODE_PUSH_HEAD: begin
                  if (sts.full) begin
                     cmd.result_status = ST_FULL;
                  end else begin
                     cmd.push_head = 1'b1;
                  end
               end
               MODE_PUSH_TAIL: begin
                  if (sts.full) begin
                     cmd.result_status = ST_FULL;
                  end else begin
                     cmd.push_tail = 1'b1;
                  end
               end
               MODE_POP_HEAD: begin
                  if (sts.empty) begin
                     cmd.result_status = ST_ABSENT;
                  end else begin
                     cmd.pop_head = 1'b1;
                  end
               end
               MODE_POP_TAIL: begin
                  if (sts.empty) begin
                     cmd.result_status = ST_ABSENT;
                  end else begin
                     cmd.pop_tail = 1'b1;
                  end
               end
               MODE_CLEAR: begin
                  cmd.clear_all = 1'b1;
               end
               MODE_READ: begin
                  if (sts.pos_ok) begin
                     cmd.read_at = 1'b1;
                     state_in    = S_RDWAIT;
                  end else begin
                     cmd.result_status = ST_ABSENT;
                  end
               end
               MODE_WRITE: begin
                  if (sts.pos_ok) begin
                     cmd.write_at = 1'b1;
                  end else begin
                     cmd.result_status = ST_ABSENT;
                  end
               end
               MODE_DELETE: begin
                  // Deleting the head is a pop; deleting the tail only
                  // shrinks the count; anything between needs a shift.
                  if (!sts.pos_ok) begin
                     cmd.result_status = ST_BAD_POS;
                  end else if (sts.pos_zero) begin
                     cmd.pop_head = 1'b1;
                  end else if (sts.more_after_pos) begin
                     cmd.shift_start = 1'b1;
                     state_in        = S_SHIFT;
                  end else begin
                     cmd.pop_tail = 1'b1;
                  end
               end
               default: begin
                  cmd.result_status = ST_OK;
               end
            endcase
         end
         S_RDWAIT: begin
            cmd.capture_read = 1'b1;
            state_in         = S_EMIT;
         end
         S_SHIFT: begin
            // Each cycle moves one entry toward the head and reads the next.
            cmd.shift_step = 1'b1;
            if (!sts.shift_more) begin
               cmd.pop_tail = 1'b1;
               state_in     = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response valid: set on load, cleared when the beat is taken.
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
